FILE: sv/ssi_pkg.sv
// Package for the sphere segment interpolator.
// Holds the sizes, action codes and the controller/datapath command and status types.
// No dependencies.
package ssi_pkg;

  localparam int MAX_SPHERES = 400;
  localparam int MAX_STEPS   = 63;

  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int STEP_W    = 6;
  localparam int COLOR_W   = 48;
  localparam int TYPE_W    = 8;
  localparam int SLOT_W    = 9;
  localparam int ACTION_W  = 2;
  localparam int LANES     = 4;
  localparam int CNT_W     = $clog2(MAX_SPHERES + 1);
  localparam int N_W       = $clog2(MAX_STEPS + 2);
  localparam int DIV_CNT_W = $clog2(COORD_W);

  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEGMENT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POINT   = 2'd2;

  typedef struct packed {
    logic load;
    logic point;
    logic clr_count;
    logic div_step;
    logic emit;
  } ssi_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
    logic run_end;
  } ssi_status_t;

endpackage

FILE: sv/sphere_segment_interpolator_top.sv
// Top level of the sphere segment interpolator.
// Joins the controller ssi_ctrl and the datapath ssi_dp. Depends on ssi_pkg.
//
// Turns path segments into spheres with consecutive store slots. A segment
// item is accepted, then divided in the bit-serial restoring divider (four
// lanes, one quotient bit each per cycle, x, y, z and radius in parallel),
// then emitted as one sphere per cycle out of the accumulators while the
// output register is free. A final-point item is accepted and emitted as one
// sphere; a clear item resets the store count. A full store ends the run with
// one overflow result. The output register holds a result until it is taken;
// the next item is accepted while the last result of the previous one still waits.
module sphere_segment_interpolator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [ssi_pkg::ACTION_W-1:0] in_action,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_z,
  input  logic        [ssi_pkg::RAD_W-1:0]    in_start_radius,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_y,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_z,
  input  logic        [ssi_pkg::RAD_W-1:0]    in_end_radius,
  input  logic        [ssi_pkg::STEP_W-1:0]   in_steps,
  input  logic        [ssi_pkg::COLOR_W-1:0]  in_color_packed,
  input  logic        [ssi_pkg::TYPE_W-1:0]   in_object_type,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssi_pkg::COORD_W-1:0]  out_pos_x,
  output logic signed [ssi_pkg::COORD_W-1:0]  out_pos_y,
  output logic signed [ssi_pkg::COORD_W-1:0]  out_pos_z,
  output logic        [ssi_pkg::RAD_W-1:0]    out_radius,
  output logic        [ssi_pkg::COLOR_W-1:0]  out_color_out,
  output logic        [ssi_pkg::TYPE_W-1:0]   out_type_out,
  output logic        [ssi_pkg::SLOT_W-1:0]   out_slot,
  output logic                                out_last,
  output logic                                out_overflow
);
  import ssi_pkg::*;

  ssi_cmd_t    cmd;
  ssi_status_t status;

  ssi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssi_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_start_z      (in_start_z),
    .in_start_radius (in_start_radius),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_end_z        (in_end_z),
    .in_end_radius   (in_end_radius),
    .in_steps        (in_steps),
    .in_color_packed (in_color_packed),
    .in_object_type  (in_object_type),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_radius      (out_radius),
    .out_color_out   (out_color_out),
    .out_type_out    (out_type_out),
    .out_slot        (out_slot),
    .out_last        (out_last),
    .out_overflow    (out_overflow)
  );

endmodule

FILE: sv/ssi_ctrl.sv
// Controller for the sphere segment interpolator.
// Sequences accept, divide and emit phases; drives ssi_dp through ssi_cmd_t.
// Depends on ssi_pkg.
module ssi_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [ssi_pkg::ACTION_W-1:0]   in_action,
  output logic                           in_ready,
  input  ssi_pkg::ssi_status_t           status,
  output ssi_pkg::ssi_cmd_t              cmd
);
  import ssi_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_CLEAR: begin
              cmd.clr_count = 1'b1;
            end
            ACT_SEGMENT: begin
              cmd.load  = 1'b1;
              state_nxt = ST_DIV;
            end
            ACT_POINT: begin
              cmd.load  = 1'b1;
              cmd.point = 1'b1;
              state_nxt = ST_EMIT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.run_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/ssi_dp.sv
// Datapath for the sphere segment interpolator.
// Four restoring divider lanes, step accumulators, store count and output register.
// Depends on ssi_pkg.
module ssi_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssi_pkg::ssi_cmd_t                   cmd,
  output ssi_pkg::ssi_status_t                status,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_z,
  input  logic        [ssi_pkg::RAD_W-1:0]    in_start_radius,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_y,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_z,
  input  logic        [ssi_pkg::RAD_W-1:0]    in_end_radius,
  input  logic        [ssi_pkg::STEP_W-1:0]   in_steps,
  input  logic        [ssi_pkg::COLOR_W-1:0]  in_color_packed,
  input  logic        [ssi_pkg::TYPE_W-1:0]   in_object_type,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssi_pkg::COORD_W-1:0]  out_pos_x,
  output logic signed [ssi_pkg::COORD_W-1:0]  out_pos_y,
  output logic signed [ssi_pkg::COORD_W-1:0]  out_pos_z,
  output logic        [ssi_pkg::RAD_W-1:0]    out_radius,
  output logic        [ssi_pkg::COLOR_W-1:0]  out_color_out,
  output logic        [ssi_pkg::TYPE_W-1:0]   out_type_out,
  output logic        [ssi_pkg::SLOT_W-1:0]   out_slot,
  output logic                                out_last,
  output logic                                out_overflow
);
  import ssi_pkg::*;

  logic [COORD_W:0]   s_ext    [LANES];
  logic [COORD_W:0]   e_ext    [LANES];
  logic [COORD_W:0]   diff     [LANES];
  logic [COORD_W:0]   diff_neg [LANES];
  logic [COORD_W-1:0] mag      [LANES];
  logic [N_W:0]       shifted  [LANES];
  logic [N_W:0]       trial    [LANES];
  logic               ge       [LANES];
  logic [N_W:0]       r_sum    [LANES];
  logic               wrap     [LANES];
  logic [COORD_W-1:0] val      [LANES];

  logic [COORD_W-1:0] base_r [LANES];
  logic               neg_r  [LANES];
  logic [COORD_W-1:0] quo_r  [LANES];
  logic [N_W-1:0]     rem_r  [LANES];
  logic [COORD_W-1:0] accq_r [LANES];
  logic [N_W-1:0]     accr_r [LANES];

  logic [N_W-1:0]       n_r;
  logic [STEP_W-1:0]    idx_r;
  logic [STEP_W-1:0]    last_idx_r;
  logic [STEP_W-1:0]    steps_sat;
  logic [STEP_W-1:0]    last_idx_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W-1:0]     count_r;
  logic [COLOR_W-1:0]   color_r;
  logic [TYPE_W-1:0]    type_r;
  logic                 full;

  logic                 out_valid_r;
  logic [COORD_W-1:0]   out_x_r;
  logic [COORD_W-1:0]   out_y_r;
  logic [COORD_W-1:0]   out_z_r;
  logic [RAD_W-1:0]     out_rad_r;
  logic [COLOR_W-1:0]   out_color_r;
  logic [TYPE_W-1:0]    out_type_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_last_r;
  logic                 out_ovf_r;

  always_comb begin
    s_ext[0] = {in_start_x[COORD_W-1], in_start_x};
    s_ext[1] = {in_start_y[COORD_W-1], in_start_y};
    s_ext[2] = {in_start_z[COORD_W-1], in_start_z};
    s_ext[3] = {{(COORD_W + 1 - RAD_W){1'b0}}, in_start_radius};
    e_ext[0] = {in_end_x[COORD_W-1], in_end_x};
    e_ext[1] = {in_end_y[COORD_W-1], in_end_y};
    e_ext[2] = {in_end_z[COORD_W-1], in_end_z};
    e_ext[3] = {{(COORD_W + 1 - RAD_W){1'b0}}, in_end_radius};
    for (int i = 0; i < LANES; i++) begin
      diff[i]     = e_ext[i] - s_ext[i];
      diff_neg[i] = ~diff[i] + 1'b1;
      mag[i]      = diff[i][COORD_W] ? diff_neg[i][COORD_W-1:0] : diff[i][COORD_W-1:0];
      shifted[i]  = {rem_r[i], quo_r[i][COORD_W-1]};
      trial[i]    = shifted[i] - {1'b0, n_r};
      ge[i]       = (shifted[i] >= {1'b0, n_r});
      r_sum[i]    = {1'b0, accr_r[i]} + {1'b0, rem_r[i]};
      wrap[i]     = (r_sum[i] >= {1'b0, n_r});
      val[i]      = neg_r[i] ? (base_r[i] - accq_r[i]) : (base_r[i] + accq_r[i]);
    end
  end

  assign steps_sat    = (in_steps > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : in_steps;
  assign last_idx_nxt = cmd.point ? '0 : steps_sat;
  assign full         = (count_r >= CNT_W'(MAX_SPHERES));

  assign status.div_done = (div_cnt_r == DIV_CNT_W'(COORD_W - 1));
  assign status.out_free = !out_valid_r || out_ready;
  assign status.run_end  = full || (idx_r == last_idx_r);

  // Lane datapath: load, divide, accumulate
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < LANES; i++) begin
        base_r[i] <= s_ext[i][COORD_W-1:0];
        neg_r[i]  <= diff[i][COORD_W];
        quo_r[i]  <= mag[i];
        rem_r[i]  <= '0;
        accq_r[i] <= '0;
        accr_r[i] <= '0;
      end
      n_r        <= N_W'({1'b0, last_idx_nxt} + 1'b1);
      idx_r      <= '0;
      last_idx_r <= last_idx_nxt;
      color_r    <= in_color_packed;
      type_r     <= in_object_type;
    end else if (cmd.div_step) begin
      for (int i = 0; i < LANES; i++) begin
        rem_r[i] <= ge[i] ? trial[i][N_W-1:0] : shifted[i][N_W-1:0];
        quo_r[i] <= {quo_r[i][COORD_W-2:0], ge[i]};
      end
    end else if (cmd.emit && !full) begin
      for (int i = 0; i < LANES; i++) begin
        accq_r[i] <= accq_r[i] + quo_r[i] + COORD_W'(wrap[i]);
        accr_r[i] <= wrap[i] ? N_W'(r_sum[i] - {1'b0, n_r}) : r_sum[i][N_W-1:0];
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  // Divide counter and store count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.load) begin
        div_cnt_r <= '0;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      if (cmd.clr_count) begin
        count_r <= '0;
      end else if (cmd.emit && !full) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (full) begin
        out_x_r     <= '0;
        out_y_r     <= '0;
        out_z_r     <= '0;
        out_rad_r   <= '0;
        out_color_r <= '0;
        out_type_r  <= '0;
        out_slot_r  <= '0;
        out_last_r  <= 1'b1;
        out_ovf_r   <= 1'b1;
      end else begin
        out_x_r     <= val[0];
        out_y_r     <= val[1];
        out_z_r     <= val[2];
        out_rad_r   <= val[3][RAD_W-1:0];
        out_color_r <= color_r;
        out_type_r  <= type_r;
        out_slot_r  <= SLOT_W'(count_r);
        out_last_r  <= (idx_r == last_idx_r);
        out_ovf_r   <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_pos_z     = out_z_r;
  assign out_radius    = out_rad_r;
  assign out_color_out = out_color_r;
  assign out_type_out  = out_type_r;
  assign out_slot      = out_slot_r;
  assign out_last      = out_last_r;
  assign out_overflow  = out_ovf_r;

endmodule

FILE: sv/ssi_checker.sv
// Port-level checker for the sphere segment interpolator, bound to the top level.
// Depends on ssi_pkg and sphere_segment_interpolator_top.
module ssi_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ssi_pkg::COORD_W-1:0]  out_pos_x,
  input logic        [ssi_pkg::RAD_W-1:0]    out_radius,
  input logic        [ssi_pkg::SLOT_W-1:0]   out_slot,
  input logic                                out_last,
  input logic                                out_overflow
);
  import ssi_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_slot) && $stable(out_last))
    else $error("result changed while stalled");

  a_ovf_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_last && out_slot == '0 && out_pos_x == '0 && out_radius == '0)
    else $error("overflow result not final or not zeroed");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> out_slot < SLOT_W'(MAX_SPHERES))
    else $error("slot beyond store");

  a_slot_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_overflow || out_slot == SLOT_W'($past(out_slot) + 1'b1)))
    else $error("run did not continue with the next slot");

endmodule

bind sphere_segment_interpolator_top ssi_checker u_ssi_checker (.*);

FILE: verif/sphere_store_checker.sv
// Checker for the sphere segment interpolator: watches both channels, predicts spheres.
// Keeps its own store count and a queue of expected spheres. Depends on ssi_pkg.
`timescale 1ns / 100ps

module sphere_store_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic        [ssi_pkg::ACTION_W-1:0] in_action,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_x,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_y,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_start_z,
  input  logic        [ssi_pkg::RAD_W-1:0]    in_start_radius,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_x,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_y,
  input  logic signed [ssi_pkg::COORD_W-1:0]  in_end_z,
  input  logic        [ssi_pkg::RAD_W-1:0]    in_end_radius,
  input  logic        [ssi_pkg::STEP_W-1:0]   in_steps,
  input  logic        [ssi_pkg::COLOR_W-1:0]  in_color_packed,
  input  logic        [ssi_pkg::TYPE_W-1:0]   in_object_type,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [ssi_pkg::COORD_W-1:0]  out_pos_x,
  input  logic signed [ssi_pkg::COORD_W-1:0]  out_pos_y,
  input  logic signed [ssi_pkg::COORD_W-1:0]  out_pos_z,
  input  logic        [ssi_pkg::RAD_W-1:0]    out_radius,
  input  logic        [ssi_pkg::COLOR_W-1:0]  out_color_out,
  input  logic        [ssi_pkg::TYPE_W-1:0]   out_type_out,
  input  logic        [ssi_pkg::SLOT_W-1:0]   out_slot,
  input  logic                                out_last,
  input  logic                                out_overflow,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  results_seen,
  output int                                  overflows_seen
);
  import ssi_pkg::*;

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic        [RAD_W-1:0]   radius;
    logic        [COLOR_W-1:0] color;
    logic        [TYPE_W-1:0]  kind;
    logic        [SLOT_W-1:0]  slot;
    logic                      last;
    logic                      overflow;
  } sphere_t;

  sphere_t expected_spheres[$];
  sphere_t want;
  int      spheres_stored;

  function automatic longint lerp(longint s, longint e, longint a, longint n);
    return s + ((e - s) * a) / n;
  endfunction

  function automatic bit store_sphere(longint x, longint y, longint z, longint r,
                                      logic [COLOR_W-1:0] c, logic [TYPE_W-1:0] k,
                                      logic is_last);
    sphere_t s;
    s = '0;
    if (spheres_stored >= MAX_SPHERES) begin
      s.last = 1'b1;
      s.overflow = 1'b1;
      expected_spheres.push_back(s);
      return 1'b0;
    end
    s.pos_x  = x[COORD_W-1:0];
    s.pos_y  = y[COORD_W-1:0];
    s.pos_z  = z[COORD_W-1:0];
    s.radius = r[RAD_W-1:0];
    s.color  = c;
    s.kind   = k;
    s.slot   = SLOT_W'(spheres_stored);
    s.last   = is_last;
    expected_spheres.push_back(s);
    spheres_stored++;
    return 1'b1;
  endfunction

  task automatic predict_spheres();
    longint n;
    longint sr;
    longint er;
    bit     ok;
    sr = longint'(in_start_radius);
    er = longint'(in_end_radius);
    case (in_action)
      ACT_CLEAR: begin
        spheres_stored = 0;
      end
      ACT_POINT: begin
        ok = store_sphere(longint'(in_start_x), longint'(in_start_y), longint'(in_start_z),
                          sr, in_color_packed, in_object_type, 1'b1);
      end
      ACT_SEGMENT: begin
        n = (in_steps > STEP_W'(MAX_STEPS)) ? longint'(MAX_STEPS) + 1
                                            : longint'(in_steps) + 1;
        for (longint a = 0; a < n; a++) begin
          ok = store_sphere(lerp(longint'(in_start_x), longint'(in_end_x), a, n),
                            lerp(longint'(in_start_y), longint'(in_end_y), a, n),
                            lerp(longint'(in_start_z), longint'(in_end_z), a, n),
                            lerp(sr, er, a, n),
                            in_color_packed, in_object_type, a == n - 1);
          if (!ok) break;
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                 input logic [63:0] got_val);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: mismatch on result %0d, %s: expected %h, got %h",
               $realtime, results_seen, what, exp_val, got_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_spheres.delete();
      spheres_stored = 0;
      mismatches = 0;
      results_seen = 0;
      overflows_seen = 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) predict_spheres();
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_overflow) overflows_seen++;
        if (expected_spheres.size() == 0) begin
          report_mismatch("transfer with nothing expected", '0, '0);
        end else begin
          want = expected_spheres.pop_front();
          if (out_pos_x !== want.pos_x)
            report_mismatch("pos_x", 64'(want.pos_x), 64'(out_pos_x));
          if (out_pos_y !== want.pos_y)
            report_mismatch("pos_y", 64'(want.pos_y), 64'(out_pos_y));
          if (out_pos_z !== want.pos_z)
            report_mismatch("pos_z", 64'(want.pos_z), 64'(out_pos_z));
          if (out_radius !== want.radius)
            report_mismatch("radius", 64'(want.radius), 64'(out_radius));
          if (out_color_out !== want.color)
            report_mismatch("color", 64'(want.color), 64'(out_color_out));
          if (out_type_out !== want.kind)
            report_mismatch("type", 64'(want.kind), 64'(out_type_out));
          if (out_slot !== want.slot)
            report_mismatch("slot", 64'(want.slot), 64'(out_slot));
          if (out_last !== want.last)
            report_mismatch("last", 64'(want.last), 64'(out_last));
          if (out_overflow !== want.overflow)
            report_mismatch("overflow", 64'(want.overflow), 64'(out_overflow));
        end
      end
      pending <= expected_spheres.size();
    end
  end

endmodule

FILE: verif/sphere_segment_interpolator_top_test.sv
// Testbench top for the sphere segment interpolator: directed and random path items.
// Drives both channels with bursts and stalls; checking is in sphere_store_checker.
// Depends on ssi_pkg, sphere_segment_interpolator_top and sphere_store_checker.
`timescale 1ns / 100ps

module sphere_segment_interpolator_top_test;
  import ssi_pkg::*;

  localparam int ITEMS        = 360;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 120;

  localparam logic [ACTION_W-1:0]       ACT_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [RAD_W-1:0]          RAD_MAX    = '1;

  typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  typedef struct {
    logic        [ACTION_W-1:0] action;
    logic signed [COORD_W-1:0]  sx, sy, sz;
    logic        [RAD_W-1:0]    sr;
    logic signed [COORD_W-1:0]  ex, ey, ez;
    logic        [RAD_W-1:0]    er;
    logic        [STEP_W-1:0]   steps;
    logic        [COLOR_W-1:0]  color;
    logic        [TYPE_W-1:0]   kind;
  } path_item_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic        [ACTION_W-1:0] in_action;
  logic signed [COORD_W-1:0]  in_start_x, in_start_y, in_start_z;
  logic        [RAD_W-1:0]    in_start_radius;
  logic signed [COORD_W-1:0]  in_end_x, in_end_y, in_end_z;
  logic        [RAD_W-1:0]    in_end_radius;
  logic        [STEP_W-1:0]   in_steps;
  logic        [COLOR_W-1:0]  in_color_packed;
  logic        [TYPE_W-1:0]   in_object_type;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [COORD_W-1:0]  out_pos_x, out_pos_y, out_pos_z;
  logic        [RAD_W-1:0]    out_radius;
  logic        [COLOR_W-1:0]  out_color_out;
  logic        [TYPE_W-1:0]   out_type_out;
  logic        [SLOT_W-1:0]   out_slot;
  logic                       out_last;
  logic                       out_overflow;

  int mismatches, pending, results_seen, overflows_seen;
  int n_segments, n_points, n_clears, n_unused;

  sphere_segment_interpolator_top dut (.*);

  sphere_store_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic path_item_t make_item(
      logic [ACTION_W-1:0] action,
      logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
      logic signed [COORD_W-1:0] sz, logic [RAD_W-1:0] sr,
      logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey,
      logic signed [COORD_W-1:0] ez, logic [RAD_W-1:0] er,
      logic [STEP_W-1:0] steps, logic [COLOR_W-1:0] color, logic [TYPE_W-1:0] kind);
    path_item_t it;
    it.action = action;
    it.sx = sx; it.sy = sy; it.sz = sz; it.sr = sr;
    it.ex = ex; it.ey = ey; it.ez = ez; it.er = er;
    it.steps = steps;
    it.color = color;
    it.kind = kind;
    return it;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    logic signed [COORD_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3, 4: return v >>> $urandom_range(8, 28);
      default: return v;
    endcase
  endfunction

  function automatic logic [RAD_W-1:0] pick_radius();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RAD_MAX;
      2, 3: return RAD_W'($urandom_range(0, 1 << 20));
      default: return RAD_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_steps();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return STEP_W'(MAX_STEPS);
      2, 3, 4: return STEP_W'($urandom_range(1, 7));
      default: return STEP_W'($urandom_range(0, MAX_STEPS));
    endcase
  endfunction

  function automatic path_item_t random_item();
    path_item_t it;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) it.action = ACT_CLEAR;
    else if (pick < 64) it.action = ACT_SEGMENT;
    else if (pick < 94) it.action = ACT_POINT;
    else it.action = ACT_UNUSED;
    it.sx = pick_coord(); it.sy = pick_coord(); it.sz = pick_coord();
    it.ex = pick_coord(); it.ey = pick_coord(); it.ez = pick_coord();
    it.sr = pick_radius();
    it.er = pick_radius();
    it.steps = pick_steps();
    it.color = COLOR_W'({$urandom, $urandom});
    it.kind = TYPE_W'($urandom);
    return it;
  endfunction

  task automatic send_item(input path_item_t it);
    in_valid        <= 1'b1;
    in_action       <= it.action;
    in_start_x      <= it.sx;
    in_start_y      <= it.sy;
    in_start_z      <= it.sz;
    in_start_radius <= it.sr;
    in_end_x        <= it.ex;
    in_end_y        <= it.ey;
    in_end_z        <= it.ez;
    in_end_radius   <= it.er;
    in_steps        <= it.steps;
    in_color_packed <= it.color;
    in_object_type  <= it.kind;
    do @(posedge clk); while (!in_ready);
    case (it.action)
      ACT_CLEAR:   n_clears++;
      ACT_SEGMENT: n_segments++;
      ACT_POINT:   n_points++;
      default:     n_unused++;
    endcase
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rx_mode_t mode;
    out_ready <= 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk);
        case (mode)
          RX_STREAM: out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
          default:   out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    path_item_t it;
    int         counted;
    int         burst;
    int         gap;
    bit         paused;
    in_valid        <= 1'b0;
    in_action       <= ACT_CLEAR;
    in_start_x      <= '0;
    in_start_y      <= '0;
    in_start_z      <= '0;
    in_start_radius <= '0;
    in_end_x        <= '0;
    in_end_y        <= '0;
    in_end_z        <= '0;
    in_end_radius   <= '0;
    in_steps        <= '0;
    in_color_packed <= '0;
    in_object_type  <= '0;
    rst_n           <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(make_item(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_item(make_item(ACT_POINT, COORD_MAX, COORD_MIN, '0, RAD_MAX,
                        COORD_MIN, COORD_MAX, COORD_MAX, '0, STEP_W'(MAX_STEPS),
                        '1, 8'hff));
    send_item(make_item(ACT_POINT, '0, '0, '0, '0,
                        COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX, '0, '0, '0));
    send_item(make_item(ACT_SEGMENT, COORD_MIN, COORD_MAX, '0, '0,
                        COORD_MAX, COORD_MIN, -1, RAD_MAX, '0, 48'h0123_4567_89ab, 8'h01));
    send_item(make_item(ACT_SEGMENT, COORD_MIN, COORD_MAX, -1, '0,
                        COORD_MAX, COORD_MIN, 1, RAD_MAX, STEP_W'(MAX_STEPS),
                        48'haaaa_5555_aaaa, 8'h5a));
    send_item(make_item(ACT_SEGMENT, COORD_MAX, COORD_MIN, 1, RAD_MAX,
                        COORD_MIN, COORD_MAX, -1, '0, STEP_W'(MAX_STEPS),
                        48'h5555_aaaa_5555, 8'ha5));
    send_item(make_item(ACT_SEGMENT, '0, '0, -1, 31'd1,
                        -3, 3, -4, 31'd4, 6'd1, 48'hffff_0000_ffff, 8'h80));
    it = random_item();
    it.action = ACT_UNUSED;
    send_item(it);
    // fill the store and run into the full condition partway through a segment
    repeat (5) begin
      it = random_item();
      it.action = ACT_SEGMENT;
      it.steps = STEP_W'(MAX_STEPS);
      send_item(it);
    end
    it = random_item();
    it.action = ACT_POINT;
    send_item(it);
    send_item(make_item(ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    it = random_item();
    it.action = ACT_POINT;
    send_item(it);
    in_valid <= 1'b0;
    drain_results();

    counted = 0;
    paused = 1'b0;
    while (counted < ITEMS) begin
      burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
      repeat (burst) begin
        it = random_item();
        send_item(it);
        if (it.action != ACT_UNUSED) counted++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0 || (!paused && counted >= ITEMS / 2)) begin
        in_valid <= 1'b0;
        if (!paused && counted >= ITEMS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d segments, %0d final points, %0d clears and %0d unused actions",
             n_segments, n_points, n_clears, n_unused);
    $display("Checked %0d spheres, %0d of them store-full reports, %0d mismatches",
             results_seen, overflows_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
